// File: sv/crsf_rc_frame_receiver_core_macros.svh
// assertion macros shared by the checker of the rc frame receiver
// depends on nothing; taken in by `include
`ifndef CRSF_RC_FRAME_RECEIVER_CORE_MACROS_SVH
`define CRSF_RC_FRAME_RECEIVER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CRSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CRSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/crsf_pkg.sv
// package of the rc frame receiver: constants, status codes, control types
// and the crc-8 step; used by every module of the block
package crsf_pkg;

  localparam int unsigned MAX_BYTES_DEF = 64;
  localparam int unsigned CHAN_COUNT    = 16;
  localparam int unsigned PAYLOAD_BYTES = 22;
  localparam int unsigned CHAN_W        = 11;
  localparam int unsigned CHAN_IDX_W    = 4;
  localparam int unsigned PAY_IDX_W     = 5;
  localparam int unsigned RC_MIN_LEN    = 26;

  localparam logic [7:0]        SYNC_BYTE    = 8'hC8;
  localparam logic [7:0]        RC_TYPE      = 8'h16;
  localparam logic [7:0]        CRC_POLY     = 8'hD5;
  localparam logic [CHAN_W-1:0] CENTER_VALUE = 11'd992;

  // result status codes
  typedef enum logic [2:0] {
    ST_CH_OK  = 3'd0,
    ST_BAD    = 3'd1,
    ST_UNSUP  = 3'd2,
    ST_SHORT  = 3'd3,
    ST_DROP   = 3'd4
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    CS_RECV,
    CS_EVAL,
    CS_EMIT
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic take;
    logic eval;
    logic next;
    logic finish;
  } crsf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic res_last;
  } crsf_sts_t;

  // one byte through the crc-8, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: sv/crsf_byte_if.sv
// byte channel of the rc frame receiver: valid/ready with one frame byte
// and its end-of-frame flag; no dependencies
interface crsf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, data_byte, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

// File: sv/crsf_res_if.sv
// result channel of the rc frame receiver: valid/ready with status,
// channel value and frame counters; no dependencies
interface crsf_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic        result_last;
  logic [7:0]  type_seen;
  logic [31:0] frames_total;
  logic [31:0] frames_good;
  logic [31:0] frames_bad;

  modport source (output valid, status, channel_index, channel_value, result_last,
                  type_seen, frames_total, frames_good, frames_bad, input ready);
  modport sink   (input valid, status, channel_index, channel_value, result_last,
                  type_seen, frames_total, frames_good, frames_bad, output ready);
endinterface

// File: sv/crsf_rc_frame_receiver_core.sv
// rc channels frame receiver, top level.
// byte_i takes one frame byte per request, frame_end marking the last byte.
// res_o gives the results of a frame once its last byte is in: sixteen
// channel results (index 0..15, last flag on 15) for a good rc channels
// frame, otherwise one status result. Every result carries the frame type
// and the total, good and bad frame counters after that frame.
// Bytes are taken one per cycle while no frame is under evaluation and no
// result is outstanding. After the last byte the frame checks run in the
// evaluate state, then the results follow, one per cycle while res_o.ready
// is high; the next byte is taken the cycle after the final result leaves.
// A stalled receiver holds the current result and byte_i.ready stays low.
// Reset clears the frame state and counters and sets every stored channel
// to 992; the block is ready to take bytes as soon as reset is released.
module crsf_rc_frame_receiver_core #(
  parameter int unsigned MaxBytes = crsf_pkg::MAX_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crsf_byte_if.sink   byte_i,
  crsf_res_if.source  res_o
);
  import crsf_pkg::*;

  crsf_cmd_t cmd;
  crsf_sts_t sts;

  // sequencing
  crsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_i.valid),
    .frame_end_i (byte_i.frame_end),
    .in_ready_o  (byte_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // frame state, stores and counters
  crsf_dp #(
    .MaxBytes (MaxBytes)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .data_byte_i     (byte_i.data_byte),
    .status_o        (res_o.status),
    .channel_index_o (res_o.channel_index),
    .channel_value_o (res_o.channel_value),
    .result_last_o   (res_o.result_last),
    .type_seen_o     (res_o.type_seen),
    .frames_total_o  (res_o.frames_total),
    .frames_good_o   (res_o.frames_good),
    .frames_bad_o    (res_o.frames_bad)
  );

endmodule

// File: sv/crsf_ctrl.sv
// controller of the rc frame receiver: receive, evaluate and emit states
// depends on crsf_pkg
module crsf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 frame_end_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  crsf_pkg::crsf_sts_t  sts_i,
  output crsf_pkg::crsf_cmd_t  cmd_o
);
  import crsf_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_RECV;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      CS_RECV: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (frame_end_i) state_d = CS_EVAL;
        end
      end
      CS_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = CS_EMIT;
      end
      CS_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.res_last) begin
            cmd_o.finish = 1'b1;
            state_d      = CS_RECV;
          end else begin
            cmd_o.next = 1'b1;
          end
        end
      end
      default: state_d = CS_RECV;
    endcase
  end

endmodule

// File: sv/crsf_dp.sv
// datapath of the rc frame receiver: frame parse, crc, payload and channel
// stores, frame counters and the result register; depends on crsf_pkg
module crsf_dp #(
  parameter int unsigned MaxBytes = crsf_pkg::MAX_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crsf_pkg::crsf_cmd_t  cmd_i,
  output crsf_pkg::crsf_sts_t  sts_o,
  input  logic [7:0]           data_byte_i,
  output logic [2:0]           status_o,
  output logic [3:0]           channel_index_o,
  output logic [10:0]          channel_value_o,
  output logic                 result_last_o,
  output logic [7:0]           type_seen_o,
  output logic [31:0]          frames_total_o,
  output logic [31:0]          frames_good_o,
  output logic [31:0]          frames_bad_o
);
  import crsf_pkg::*;

  localparam int unsigned PosW = $clog2(MaxBytes + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MaxBytes);
  localparam logic [PosW-1:0] PayOff = PosW'(3);

  logic [PosW-1:0]   pos_q, pos_d;
  logic              over_q, over_d;
  logic              sync_q, sync_d;
  logic [7:0]        size_q, size_d;
  logic [7:0]        type_q, type_d;
  logic [7:0]        crc_q, crc_d;
  logic [7:0]        prev_q, prev_d;
  logic [7:0]        last_byte_q;
  logic [7:0]        pay_q [PAYLOAD_BYTES];
  logic [CHAN_W-1:0] chan_q [CHAN_COUNT];
  logic [31:0]       total_q, good_q, bad_q;
  status_e           status_q, status_d;
  logic [CHAN_IDX_W-1:0] idx_q;

  logic                 byte_live;
  logic [PosW-1:0]      pay_off;
  logic                 pay_we;
  logic [PAYLOAD_BYTES*8-1:0] pay_flat;
  logic                 drop, bad, unsup, too_short;
  logic [8:0]           size_plus2;

  assign byte_live = cmd_i.take && !over_q && (pos_q < PosMax);
  assign pay_off   = pos_q - PayOff;
  assign pay_we    = byte_live && (pos_q >= PayOff) && (pay_off < PosW'(PAYLOAD_BYTES));

  // per-byte frame state
  always_comb begin
    pos_d  = pos_q;
    over_d = over_q;
    sync_d = sync_q;
    size_d = size_q;
    type_d = type_q;
    crc_d  = crc_q;
    prev_d = prev_q;
    if (cmd_i.take && !over_q && !byte_live) begin
      over_d = 1'b1;
    end
    if (byte_live) begin
      if (pos_q == PosW'(0)) sync_d = (data_byte_i == SYNC_BYTE);
      if (pos_q == PosW'(1)) size_d = data_byte_i;
      if (pos_q == PosW'(2)) type_d = data_byte_i;
      if (pos_q >= PayOff) crc_d = crc8_step(crc_q, prev_q);
      prev_d = data_byte_i;
      pos_d  = pos_q + PosW'(1);
    end
    if (cmd_i.finish) begin
      pos_d  = '0;
      over_d = 1'b0;
      sync_d = 1'b0;
      size_d = '0;
      type_d = '0;
      crc_d  = '0;
      prev_d = '0;
    end
  end

  // end-of-frame checks
  assign size_plus2 = {1'b0, size_q} + 9'd2;
  assign drop       = over_q || (pos_q < PosW'(3));
  assign bad        = (pos_q < PosW'(4)) || !sync_q || (size_plus2 != 9'(pos_q))
                      || (crc_q != last_byte_q);
  assign unsup      = (type_q != RC_TYPE);
  assign too_short  = (pos_q < PosW'(RC_MIN_LEN));

  always_comb begin
    if (drop)           status_d = ST_DROP;
    else if (bad)       status_d = ST_BAD;
    else if (unsup)     status_d = ST_UNSUP;
    else if (too_short) status_d = ST_SHORT;
    else                status_d = ST_CH_OK;
  end

  // payload bytes laid out little-endian for channel unpacking
  always_comb begin
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      pay_flat[8*k +: 8] = pay_q[k];
    end
  end

  // control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      over_q   <= 1'b0;
      sync_q   <= 1'b0;
      size_q   <= '0;
      type_q   <= '0;
      crc_q    <= '0;
      prev_q   <= '0;
      total_q  <= '0;
      good_q   <= '0;
      bad_q    <= '0;
      status_q <= ST_CH_OK;
      idx_q    <= '0;
      for (int i = 0; i < CHAN_COUNT; i++) chan_q[i] <= CENTER_VALUE;
    end else begin
      pos_q  <= pos_d;
      over_q <= over_d;
      sync_q <= sync_d;
      size_q <= size_d;
      type_q <= type_d;
      crc_q  <= crc_d;
      prev_q <= prev_d;
      if (cmd_i.eval) begin
        status_q <= status_d;
        idx_q    <= '0;
        if (!drop) total_q <= total_q + 32'd1;
        if (!drop && bad) bad_q <= bad_q + 32'd1;
        if (status_d == ST_CH_OK) begin
          good_q <= good_q + 32'd1;
          for (int i = 0; i < CHAN_COUNT; i++) chan_q[i] <= pay_flat[CHAN_W*i +: CHAN_W];
        end
      end
      if (cmd_i.next) idx_q <= idx_q + CHAN_IDX_W'(1);
    end
  end

  // payload store and end byte, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) last_byte_q <= data_byte_i;
    if (pay_we) pay_q[pay_off[PAY_IDX_W-1:0]] <= data_byte_i;
  end

  // result fields
  assign result_last_o   = (status_q != ST_CH_OK) || (idx_q == CHAN_IDX_W'(CHAN_COUNT - 1));
  assign sts_o.res_last  = result_last_o;
  assign status_o        = status_q;
  assign channel_index_o = idx_q;
  assign channel_value_o = (status_q == ST_CH_OK) ? chan_q[idx_q] : '0;
  assign type_seen_o     = type_q;
  assign frames_total_o  = total_q;
  assign frames_good_o   = good_q;
  assign frames_bad_o    = bad_q;

endmodule

// File: sv/crsf_chk.sv
// port-level checker of the rc frame receiver, bound to the top level
// depends on crsf_pkg and the assertion macro header
`include "crsf_rc_frame_receiver_core_macros.svh"

module crsf_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [3:0]  channel_index_i,
  input logic [10:0] channel_value_i,
  input logic        result_last_i
);
  import crsf_pkg::*;

  logic out_stall;
  logic out_take;

  assign out_stall = out_valid_i && !out_ready_i;
  assign out_take  = out_valid_i && out_ready_i;

  // stalled result holds
  `CRSF_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(status_i) && $stable(channel_index_i) && $stable(channel_value_i), "result changed under stall")

  // no byte taken while a result is outstanding
  `CRSF_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, out_valid_i, !in_ready_i, "byte taken during results")

  // status-only results are single and carry no channel
  `CRSF_ASSERT_NOW(a_status_only, clk_i, rst_ni, out_valid_i && (status_i != ST_CH_OK), result_last_i && (channel_index_i == 4'd0) && (channel_value_i == 11'd0), "bad status-only result")

  // channel burst continues until its last result
  `CRSF_ASSERT_NEXT(a_burst, clk_i, rst_ni, out_take && !result_last_i, out_valid_i && (channel_index_i == $past(channel_index_i) + 4'd1), "channel burst broken")

endmodule

bind crsf_rc_frame_receiver_core crsf_chk u_crsf_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (byte_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .status_i        (res_o.status),
  .channel_index_i (res_o.channel_index),
  .channel_value_i (res_o.channel_value),
  .result_last_i   (res_o.result_last)
);

// File: sim/crsf_rc_frame_receiver_core_test.sv
// self-checking testbench of the rc channels frame receiver core
// predicts every result from the bytes it sends and checks each field
// depends on crsf_pkg, crsf_byte_if, crsf_res_if and crsf_rc_frame_receiver_core
module crsf_rc_frame_receiver_core_test;
  import crsf_pkg::*;

  localparam int unsigned MAX_LEN      = MAX_BYTES_DEF;
  localparam int unsigned RANDOM_BYTES = 24;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  // one result as it should appear on res_o
  typedef struct {
    status_e     status;
    logic [3:0]  chan_idx;
    logic [10:0] chan_val;
    logic        last;
    logic [7:0]  ftype;
    logic [31:0] total;
    logic [31:0] good;
    logic [31:0] bad;
  } frame_result_t;

  logic clk_i;
  logic rst_ni;

  crsf_byte_if byte_if ();
  crsf_res_if  res_if ();

  crsf_rc_frame_receiver_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .res_o  (res_if)
  );

  // decoder state kept alongside the block
  logic [6:0]        rx_pos;
  logic              rx_over;
  logic              rx_sync;
  logic [7:0]        rx_size;
  logic [7:0]        rx_type;
  logic [7:0]        rx_crc;
  logic [7:0]        rx_prev;
  logic [7:0]        rx_payload [PAYLOAD_BYTES];
  logic [CHAN_W-1:0] rx_chan [CHAN_COUNT];
  logic [31:0]       cnt_total;
  logic [31:0]       cnt_good;
  logic [31:0]       cnt_bad;

  frame_result_t pending_results[$];
  logic [7:0]    frame_buf[$];

  int unsigned mismatch_count    = 0;
  int unsigned bytes_sent        = 0;
  int unsigned idle_cycles       = 0;
  logic        steady_flow       = 1'b0;
  logic        hold_results      = 1'b0;

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // crc-8 dvb-s2 over one byte, msb first
  function automatic logic [7:0] crc8_dvb(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] r;
    r = acc ^ d;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    return r;
  endfunction

  function automatic void push_result(input status_e st, input logic [3:0] idx,
                                      input logic [10:0] val, input logic last);
    frame_result_t r;
    r.status   = st;
    r.chan_idx = idx;
    r.chan_val = val;
    r.last     = last;
    r.ftype    = rx_type;
    r.total    = cnt_total;
    r.good     = cnt_good;
    r.bad      = cnt_bad;
    pending_results.push_back(r);
  endfunction

  function automatic void clear_frame_state();
    rx_pos  = '0;
    rx_over = 1'b0;
    rx_sync = 1'b0;
    rx_size = '0;
    rx_type = '0;
    rx_crc  = '0;
    rx_prev = '0;
  endfunction

  // advance the decoder by one accepted byte and queue the results it causes
  task automatic decode_frame_byte(input logic [7:0] b, input logic fend);
    int                             len;
    logic [PAYLOAD_BYTES*8-1:0]     payload_bits;
    if (!rx_over) begin
      if (rx_pos >= MAX_LEN) begin
        rx_over = 1'b1;
      end else begin
        case (rx_pos)
          7'd0: rx_sync = (b == SYNC_BYTE);
          7'd1: rx_size = b;
          7'd2: rx_type = b;
          default: ;
        endcase
        if (rx_pos >= 3) begin
          rx_crc = crc8_dvb(rx_crc, rx_prev);
          if (rx_pos - 3 < PAYLOAD_BYTES) rx_payload[rx_pos - 3] = b;
        end
        rx_prev = b;
        rx_pos  = rx_pos + 1'b1;
      end
    end
    if (!fend) return;

    len = int'(rx_pos);
    if (rx_over || len < 3) begin
      push_result(ST_DROP, '0, '0, 1'b1);
    end else begin
      cnt_total++;
      if (len < 4 || !rx_sync || int'(rx_size) + 2 != len || rx_crc != b) begin
        cnt_bad++;
        push_result(ST_BAD, '0, '0, 1'b1);
      end else if (rx_type != RC_TYPE) begin
        push_result(ST_UNSUP, '0, '0, 1'b1);
      end else if (len < RC_MIN_LEN) begin
        push_result(ST_SHORT, '0, '0, 1'b1);
      end else begin
        // channels are packed lsb first across the payload
        cnt_good++;
        for (int k = 0; k < PAYLOAD_BYTES; k++) payload_bits[k*8 +: 8] = rx_payload[k];
        for (int i = 0; i < CHAN_COUNT; i++) rx_chan[i] = payload_bits[i*CHAN_W +: CHAN_W];
        for (int i = 0; i < CHAN_COUNT; i++)
          push_result(ST_CH_OK, 4'(i), rx_chan[i], i == CHAN_COUNT - 1);
      end
    end
    clear_frame_state();
  endtask

  // one byte request, with an occasional gap before it
  task automatic send_byte(input logic [7:0] b, input logic fend);
    if (!steady_flow && $urandom_range(99) < 10) begin
      byte_if.valid = 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid     = 1'b1;
    byte_if.data_byte = b;
    byte_if.frame_end = fend;
    do @(posedge clk_i); while (!byte_if.ready);
    decode_frame_byte(b, fend);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    for (int k = 0; k < frame_buf.size(); k++) send_byte(frame_buf[k], k == frame_buf.size() - 1);
  endtask

  // well-formed frame of the given type and length (at least 4 bytes)
  task automatic build_frame(input logic [7:0] ftype, input int len, input fill_e fill);
    logic [7:0] crc;
    logic [7:0] v;
    frame_buf.delete();
    frame_buf.push_back(SYNC_BYTE);
    frame_buf.push_back(8'(len - 2));
    frame_buf.push_back(ftype);
    crc = crc8_dvb(8'h00, ftype);
    for (int k = 3; k < len - 1; k++) begin
      case (fill)
        FILL_ZERO: v = 8'h00;
        FILL_ONES: v = 8'hFF;
        default:   v = 8'($urandom);
      endcase
      frame_buf.push_back(v);
      crc = crc8_dvb(crc, v);
    end
    frame_buf.push_back(crc);
  endtask

  function automatic int rc_length();
    return ($urandom_range(7) == 0) ? int'($urandom_range(MAX_LEN, RC_MIN_LEN + 1)) :
                                      int'(RC_MIN_LEN);
  endfunction

  // frames too short to count, and the three-byte frame that is counted as bad
  task automatic test_short_frames();
    frame_buf = '{SYNC_BYTE};
    send_frame();
    frame_buf = '{SYNC_BYTE, 8'h00};
    send_frame();
    frame_buf = '{SYNC_BYTE, 8'h01, RC_TYPE};
    send_frame();
  endtask

  // single-result frames: unsupported type, broken sync, size and crc, short rc
  task automatic test_status_frames();
    build_frame(8'h00, 4, FILL_RANDOM);
    send_frame();
    build_frame(RC_TYPE, 5, FILL_RANDOM);
    frame_buf[0] = frame_buf[0] ^ 8'h01;
    send_frame();
    build_frame(8'h2A, 4, FILL_RANDOM);
    frame_buf[1] = frame_buf[1] + 8'd1;
    send_frame();
    build_frame(8'h2A, 4, FILL_RANDOM);
    frame_buf[3] = frame_buf[3] ^ 8'h80;
    send_frame();
    build_frame(RC_TYPE, 5, FILL_RANDOM);
    send_frame();
  endtask

  // one byte over the limit
  task automatic test_oversize();
    build_frame(RC_TYPE, MAX_LEN, FILL_RANDOM);
    frame_buf.push_back(8'($urandom));
    send_frame();
  endtask

  // channel values at both ends, frames back to back with neither side pausing
  task automatic test_back_to_back();
    steady_flow = 1'b1;
    build_frame(RC_TYPE, RC_MIN_LEN, FILL_ZERO);
    send_frame();
    build_frame(RC_TYPE, RC_MIN_LEN, FILL_ONES);
    send_frame();
    steady_flow = 1'b0;
  endtask

  // results held back for a long stretch so byte input stalls
  task automatic test_backpressure();
    hold_results = 1'b1;
    repeat (2) begin
      build_frame(8'h08, 4, FILL_RANDOM);
      send_frame();
    end
  endtask

  // mostly well-formed frames with random content, some broken ones and noise
  task automatic test_random_traffic();
    int unsigned sent_at_start;
    int unsigned pick;
    int unsigned idx;
    sent_at_start = bytes_sent;
    while (bytes_sent - sent_at_start < RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        build_frame(RC_TYPE, rc_length(), FILL_RANDOM);
      end else if (pick < 55) begin
        build_frame(8'($urandom), $urandom_range(12, 4), FILL_RANDOM);
      end else if (pick < 65) begin
        build_frame(RC_TYPE, $urandom_range(RC_MIN_LEN - 1, 4), FILL_RANDOM);
      end else if (pick < 85) begin
        // one corrupted byte anywhere in the frame
        if ($urandom_range(1)) build_frame(RC_TYPE, rc_length(), FILL_RANDOM);
        else build_frame(8'($urandom), $urandom_range(10, 4), FILL_RANDOM);
        idx = $urandom_range(frame_buf.size() - 1);
        frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(255, 1));
      end else if (pick < 97) begin
        frame_buf.delete();
        repeat ($urandom_range(8, 1)) frame_buf.push_back(8'($urandom));
      end else begin
        build_frame(RC_TYPE, MAX_LEN, FILL_RANDOM);
        repeat ($urandom_range(4, 1)) frame_buf.push_back(8'($urandom));
      end
      send_frame();
    end
  endtask

  // result receiver: random pauses, one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_results = 1'b0;
      end else begin
        res_if.ready = steady_flow || ($urandom_range(99) >= 10);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare each accepted result with the oldest one queued
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result: none queued, got status %0d index %0d",
               res_if.status, res_if.channel_index);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(res_if.status));
        check_field("channel_index", 32'(want.chan_idx), 32'(res_if.channel_index));
        check_field("channel_value", 32'(want.chan_val), 32'(res_if.channel_value));
        check_field("result_last", 32'(want.last), 32'(res_if.result_last));
        check_field("type_seen", 32'(want.ftype), 32'(res_if.type_seen));
        check_field("frames_total", want.total, res_if.frames_total);
        check_field("frames_good", want.good, res_if.frames_good);
        check_field("frames_bad", want.bad, res_if.frames_bad);
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // reset, test sequence and final verdict
  initial begin
    rst_ni            = 1'b0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.frame_end = 1'b0;
    cnt_total         = '0;
    cnt_good          = '0;
    cnt_bad           = '0;
    clear_frame_state();
    foreach (rx_payload[k]) rx_payload[k] = '0;
    foreach (rx_chan[i]) rx_chan[i] = CENTER_VALUE;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_short_frames();
    test_status_frames();
    test_oversize();
    test_back_to_back();
    test_backpressure();
    test_random_traffic();
    byte_if.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/crsf_pkg.sv
sv/crsf_byte_if.sv
sv/crsf_res_if.sv
sv/crsf_ctrl.sv
sv/crsf_dp.sv
sv/crsf_rc_frame_receiver_core.sv
sv/crsf_chk.sv
sim/crsf_rc_frame_receiver_core_test.sv
